// ===== hw/rtl/iida_pkg.sv =====
// ----------------------------------------------------------------------------
// iida_pkg: shared definitions for the indexed insert/delete array
// Field widths, request and status codes, and the broadcast command that
// the top level hands to every storage cell.
// ----------------------------------------------------------------------------
package iida_pkg;

  // Fixed field widths.
  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 7;
  localparam int unsigned ActW  = 2;
  localparam int unsigned StW   = 2;

  // Default number of cells.
  localparam int unsigned DefCapacity = 64;

  // Cells per group of the registered read OR tree.
  localparam int unsigned GroupSize = 8;

  // Request codes.
  localparam logic [ActW-1:0] ActInsert = 2'd0;
  localparam logic [ActW-1:0] ActDelete = 2'd1;
  localparam logic [ActW-1:0] ActRead   = 2'd2;

  // Status codes.
  localparam logic [StW-1:0] StOk    = 2'd0;
  localparam logic [StW-1:0] StFull  = 2'd1;
  localparam logic [StW-1:0] StRange = 2'd2;

  // Command broadcast to every cell; ins and del are already qualified.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] value;
  } op_t;

endpackage

// ===== hw/rtl/iida_cell.sv =====
// ----------------------------------------------------------------------------
// iida_cell: one storage cell of the shift array
// Holds one entry. For a target index at or below its own, it takes on an insert
// its lower neighbor's word (the new word if equal), on a delete its upper one's.
// ----------------------------------------------------------------------------
module iida_cell import iida_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  logic             clk_i,
  input  op_t              op_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  output logic [DataW-1:0] entry_o
);

  localparam logic [31:0] Idx = 32'(INDEX);

  logic [DataW-1:0] entry_q, entry_d;
  logic [31:0]      pos_w;

  assign pos_w = 32'(op_i.pos);

  // Pick the word this cell holds after the current request.
  always_comb begin
    entry_d = entry_q;
    if (op_i.ins) begin
      if (Idx == pos_w) begin
        entry_d = op_i.value;
      end else if (Idx > pos_w) begin
        entry_d = left_i;
      end
    end else if (op_i.del && (Idx >= pos_w)) begin
      entry_d = right_i;
    end
  end

  // Entry storage; undefined until written, so no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/indexed_insert_delete_array_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_unit: ordered array with indexed insert/delete
// Usage:
//   A request word (action_i, position_i, value_i) is taken at a rising edge
//   where start is high and busy is low. Actions: insert at index (later
//   entries move up), delete at index (later entries move down), read at
//   index. busy stays low: a new request is taken in every cycle.
//   Each request returns one result word from the output registers: done_o is high
//   for exactly one cycle with read_value_o, item_count_o and status_o.
//   The receiver cannot hold results off; results leave in request order.
// Throughput and pipeline:
//   One request per cycle. Inserts and deletes finish at the accepting edge,
//   where the cells from the index up take their new words. Reads go
//   through a registered OR tree (groups of eight cells, then one final OR),
//   whose group registers feed the final OR and then the output registers.
// Reset:
//   rst_ni clears the entry count and the result valid flags. Entries are not
//   cleared; only entries below the count can be read.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_unit import iida_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [ActW-1:0]         action_i,
  input  logic [PosW-1:0]         position_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] read_value_o,
  output logic [PosW-1:0]         item_count_o,
  output logic [StW-1:0]          status_o
);

  localparam int unsigned CntW    = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW    = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned NumGrp  = (CAPACITY + GroupSize - 1) / GroupSize;
  localparam logic [CmpW-1:0] CapC = CmpW'(CAPACITY);

  logic                accept;
  logic [CmpW-1:0]     pos_ext, cnt_ext;
  logic [CntW-1:0]     count_q, count_d;
  logic [StW-1:0]      st_w;
  logic                rd_ok;
  op_t                 op;

  logic [DataW-1:0]    entry_w [CAPACITY];
  logic [DataW-1:0]    masked_w [CAPACITY];
  logic [DataW-1:0]    grp_d [NumGrp];
  logic [DataW-1:0]    grp_q [NumGrp];
  logic [DataW-1:0]    rd_d;

  logic                s1_valid_q;
  logic [PosW-1:0]     s1_count_q;
  logic [StW-1:0]      s1_status_q;

  logic                done_q;
  logic [DataW-1:0]    rd_q;
  logic [PosW-1:0]     count_out_q;
  logic [StW-1:0]      status_out_q;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign pos_ext = CmpW'(position_i);
  assign cnt_ext = CmpW'(count_q);

  // Status and new count for the request on the ports.
  always_comb begin
    st_w    = StOk;
    count_d = count_q;
    rd_ok   = 1'b0;
    op.ins  = 1'b0;
    op.del  = 1'b0;
    op.pos  = position_i;
    op.value = value_i;
    case (action_i)
      ActInsert: begin
        if (cnt_ext >= CapC) begin
          st_w = StFull;
        end else if (pos_ext > cnt_ext) begin
          st_w = StRange;
        end else begin
          op.ins  = accept;
          count_d = count_q + 1'b1;
        end
      end
      ActDelete: begin
        if (pos_ext >= cnt_ext) begin
          st_w = StRange;
        end else begin
          op.del  = accept;
          count_d = count_q - 1'b1;
        end
      end
      ActRead: begin
        if (pos_ext >= cnt_ext) begin
          st_w = StRange;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
        st_w = StRange;
      end
    endcase
  end

  // Chain of cells, each wired to its two neighbors.
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;
    if (j == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[j-1];
    end
    if (j == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_w[j+1];
    end

    iida_cell #(
      .INDEX (j)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[j])
    );

    // Only the addressed cell drives the read tree.
    assign masked_w[j] = entry_w[j] & {DataW{rd_ok && (pos_ext == CmpW'(j))}};
  end

  // First level of the read tree: OR within each group of cells.
  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GroupSize; k++) begin
        if (g * GroupSize + k < CAPACITY) begin
          grp_d[g] = grp_d[g] | masked_w[g*GroupSize+k];
        end
      end
    end
  end

  // Second level of the read tree: OR across the registered groups.
  always_comb begin
    rd_d = '0;
    for (int g = 0; g < NumGrp; g++) begin
      rd_d = rd_d | grp_q[g];
    end
  end

  // Group registers of the read tree.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      grp_q <= grp_d;
    end
  end

  // Count and first-stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // First-stage result fields.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_count_q  <= PosW'(CmpW'(count_d));
      s1_status_q <= st_w;
    end
  end

  // Output strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  // Output result word.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      rd_q         <= rd_d;
      count_out_q  <= s1_count_q;
      status_out_q <= s1_status_q;
    end
  end

  assign done_o       = done_q;
  assign read_value_o = rd_q;
  assign item_count_o = count_out_q;
  assign status_o     = status_out_q;

endmodule

// ===== hw/rtl/iida_checker.sv =====
// ----------------------------------------------------------------------------
// iida_checker: port-level checks for the indexed insert/delete array
// Watches the request and result ports and checks timing and status rules.
// ----------------------------------------------------------------------------
module iida_checker import iida_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    done_o,
  input logic signed [DataW-1:0] read_value_o,
  input logic [PosW-1:0]         item_count_o,
  input logic [StW-1:0]          status_o
);

  localparam logic [PosW-1:0] CapLow = PosW'(CAPACITY);

  // Every accepted word returns a result word through the result pipeline.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result word missing two cycles after a request");

  // No result word without a matching earlier request.
  a_no_extra : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result word without a request");

  // A full-array rejection reports a full count.
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == StFull)) |-> (item_count_o == CapLow))
    else $error("full status with a count below capacity");

  // Failed requests return a zero read word.
  a_zero_on_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != StOk)) |-> (read_value_o == '0))
    else $error("nonzero read word on a failed request");

endmodule

bind indexed_insert_delete_array_unit iida_checker #(.CAPACITY(CAPACITY)) u_iida_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: indexed insert/delete array unit
// Sends insert, delete and read request words through the start/busy
// handshake and keeps its own copy of the ordered array to predict the
// result word of every request. Each result word is checked field by field
// against the oldest prediction. A short directed run covers the edges of
// the array. Long random runs then fill the array to capacity and drain it
// again, while the sender idles at different rates.
// ----------------------------------------------------------------------------
module testbench;
  import iida_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [ActW-1:0] ActUnused = 2'd3;

  // Predicted result word.
  typedef struct {
    logic signed [DataW-1:0] read_value;
    logic [PosW-1:0]         item_count;
    logic [StW-1:0]          status;
  } result_word_t;

  // Shadow copy of the array that predicts and checks result words.
  class shift_array_model;
    logic signed [DataW-1:0] cells [DefCapacity];
    int                      item_count;
    result_word_t            pending_results [$];
    int                      mismatches;

    function new();
      item_count = 0;
      mismatches = 0;
    endfunction

    function void flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endfunction

    // Applies one accepted request word to the shadow array.
    function void note_request(logic [ActW-1:0] act, logic [PosW-1:0] pos,
                               logic signed [DataW-1:0] val);
      result_word_t exp_word;
      int           idx;
      exp_word.read_value = '0;
      exp_word.status     = StOk;
      case (act)
        ActInsert: begin
          // The full check takes priority over the index check.
          if (item_count >= DefCapacity) begin
            exp_word.status = StFull;
          end else if (int'(pos) > item_count) begin
            exp_word.status = StRange;
          end else begin
            for (idx = item_count; idx > int'(pos); idx--) cells[idx] = cells[idx-1];
            cells[int'(pos)] = val;
            item_count++;
          end
        end
        ActDelete: begin
          if (int'(pos) >= item_count) begin
            exp_word.status = StRange;
          end else begin
            for (idx = int'(pos); idx + 1 < item_count; idx++) cells[idx] = cells[idx+1];
            item_count--;
          end
        end
        ActRead: begin
          if (int'(pos) >= item_count) exp_word.status = StRange;
          else exp_word.read_value = cells[int'(pos)];
        end
        default: begin
          exp_word.status = StRange;
        end
      endcase
      exp_word.item_count = item_count[PosW-1:0];
      pending_results.push_back(exp_word);
    endfunction

    // Compares one result word with the oldest prediction.
    function void check_result(logic signed [DataW-1:0] rd, logic [PosW-1:0] cnt,
                               logic [StW-1:0] st);
      result_word_t exp_word;
      if (pending_results.size() == 0) begin
        flag_mismatch("result word with no request waiting");
        return;
      end
      exp_word = pending_results.pop_front();
      if (rd !== exp_word.read_value)
        flag_mismatch($sformatf("read_value %0d, expected %0d", rd, exp_word.read_value));
      if (cnt !== exp_word.item_count)
        flag_mismatch($sformatf("item_count %0d, expected %0d", cnt, exp_word.item_count));
      if (st !== exp_word.status)
        flag_mismatch($sformatf("status %0d, expected %0d", st, exp_word.status));
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [ActW-1:0]         action_i;
  logic [PosW-1:0]         position_i;
  logic signed [DataW-1:0] value_i;
  logic                    done_o;
  logic signed [DataW-1:0] read_value_o;
  logic [PosW-1:0]         item_count_o;
  logic [StW-1:0]          status_o;

  shift_array_model model;
  int               idle_pct;
  bit               filling;
  int unsigned      cycle_count;

  // Sender idle rates of the random phases, in percent.
  int idle_pct_list [4] = '{0, 49, 0, 37};

  indexed_insert_delete_array_unit #(
    .CAPACITY(DefCapacity)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .item_count_o (item_count_o),
    .status_o     (status_o)
  );

  // Clock with a 20 ns period.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Hard limit on the run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Every result word is taken at the edge that ends its strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) model.check_result(read_value_o, item_count_o, status_o);
  end

  // Sends one request word, idling first at the current rate.
  task automatic send_request(input logic [ActW-1:0] act, input logic [PosW-1:0] pos,
                              input logic signed [DataW-1:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    model.note_request(act, pos, val);
  endtask

  // Random request word; the mode swings the array between full and empty.
  task automatic send_random_request();
    int              cnt;
    int              roll;
    logic [ActW-1:0] act;
    logic [PosW-1:0] pos;
    cnt = model.item_count;
    if (filling && cnt == DefCapacity && $urandom_range(0, 7) == 0) filling = 1'b0;
    else if (!filling && cnt == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
    roll = $urandom_range(0, 99);
    if (roll < 4) act = ActUnused;
    else if (roll < 24) act = ActRead;
    else if (roll < (filling ? 86 : 40)) act = ActInsert;
    else act = ActDelete;
    // Mostly valid indexes, some anywhere in the 7-bit range.
    if ($urandom_range(0, 99) < 12) pos = PosW'($urandom_range(0, 127));
    else if (act == ActInsert) pos = PosW'($urandom_range(0, cnt));
    else if (cnt == 0) pos = '0;
    else pos = PosW'($urandom_range(0, cnt - 1));
    send_request(act, pos, $urandom);
  endtask

  initial begin
    model       = new();
    cycle_count = 0;
    idle_pct    = 0;
    filling     = 1'b1;
    rst_ni      = 1'b0;
    start       = 1'b0;
    action_i    = ActInsert;
    position_i  = '0;
    value_i     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty array, appends, front and middle inserts, edges.
    send_request(ActRead, 7'd0, 32'sd5);
    send_request(ActDelete, 7'd0, 32'sd0);
    send_request(ActUnused, 7'd0, 32'sd0);
    send_request(ActInsert, 7'd1, 32'sd7);
    send_request(ActInsert, 7'd0, 32'sh8000_0000);
    send_request(ActInsert, 7'd1, 32'sh7FFF_FFFF);
    send_request(ActInsert, 7'd0, -32'sd1);
    send_request(ActInsert, 7'd1, 32'sd0);
    for (int i = 0; i < 4; i++) send_request(ActRead, i[PosW-1:0], 32'sd0);
    send_request(ActRead, 7'd4, 32'sd0);
    send_request(ActRead, 7'd127, 32'sd0);
    send_request(ActDelete, 7'd1, 32'sd0);
    send_request(ActRead, 7'd1, 32'sd0);
    send_request(ActDelete, 7'd2, 32'sd0);
    send_request(ActDelete, 7'd5, 32'sd0);
    send_request(ActInsert, 7'd127, -32'sd1);
    send_request(ActUnused, 7'd127, -32'sd1);
    send_request(ActDelete, 7'd0, 32'sd0);
    send_request(ActDelete, 7'd0, 32'sd0);

    // Random phases at different sender idle rates.
    foreach (idle_pct_list[p]) begin
      idle_pct = idle_pct_list[p];
      repeat (300) send_random_request();
    end
    start <= 1'b0;

    // Drain the outstanding result words, then allow for the pipeline.
    while (model.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (model.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
